// File: hdl/bba_pkg.sv
package bba_pkg;

    // fixed field widths
    localparam int CFG_W     = 13;
    localparam int BLK_IO_W  = 12;

    // parameter defaults
    localparam int DEF_MAX_BLOCKS = 4096;
    localparam int DEF_WORD_BITS  = 64;

    // size of the managed area after reset
    localparam logic [CFG_W-1:0] FS_SIZE_RST = CFG_W'(4096);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

endpackage

// File: hdl/bba_find.sv
module bba_find #(
    parameter int WORD_BITS = 64
) (
    input  logic [WORD_BITS-1:0]         i_word,
    input  logic [$clog2(WORD_BITS)-1:0] i_rem,
    input  logic                         i_last,
    output logic                         o_found,
    output logic [$clog2(WORD_BITS)-1:0] o_idx
);

    localparam int WB_LOG = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] eff;

    // bits beyond the end of the managed area count as used
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            eff[i] = i_word[i] | (i_last & (WB_LOG'(i) > i_rem));
        end
    end

    // lowest clear bit
    always_comb begin
        o_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!eff[i]) begin
                o_idx = WB_LOG'(i);
            end
        end
    end

    assign o_found = ~&eff;

endmodule

// File: hdl/bitmap_block_allocator.sv
// Channel | Direction | Handshake             | Word
// --------+-----------+-----------------------+------------------------------------
// request | in        | i_valid / o_stall     | i_operation, i_block_number
// result  | out       | o_valid / i_stall     | o_allocated_block, o_status
// config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (fs_size)
//
// One request at a time. A free goes through ST_FREE, which clears the bit, to ST_HOLD;
// an allocate goes through ST_SCAN, which reads the bitmap words (1 up to NUM_WORDS)
// one word a cycle from the bitmap memory, to ST_HOLD; an allocate with a size of zero
// goes straight to ST_HOLD. The next request is taken in the cycle after the result load.
// Reset is synchronous; per-word valid bits make the whole bitmap read as free at once.
// A stalled result sits in the output register while the next request is taken.
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int WORD_BITS  = DEF_WORD_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_operation,
    input  logic [BLK_IO_W-1:0] i_block_number,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [BLK_IO_W-1:0] o_allocated_block,
    output logic                o_status,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WB_LOG    = $clog2(WORD_BITS);
    localparam int WI_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BLK_W     = $clog2(MAX_BLOCKS);
    localparam int LIM_W     = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W     = (LIM_W > CFG_W) ? LIM_W : CFG_W;
    localparam int RNG_W     = (LIM_W > BLK_IO_W) ? LIM_W : BLK_IO_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_FREE = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_HOLD = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0]     r_fs_size;
    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_vld;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;

    logic [WI_W-1:0]     r_chk, n_chk;
    logic [WI_W-1:0]     r_last, n_last;
    logic [WB_LOG-1:0]   r_rem, n_rem;
    logic                r_do_wr, n_do_wr;
    logic [BLK_IO_W-1:0] r_pend_blk, n_pend_blk;
    logic                r_pend_status, n_pend_status;

    logic                r_out_vld;
    logic [BLK_IO_W-1:0] r_out_blk;
    logic                r_out_status;

    logic                 accept;
    logic                 out_load;
    logic [CMP_W-1:0]     limit_sat;
    logic [LIM_W-1:0]     limit;
    logic [BLK_W-1:0]     lim_m1;
    logic                 in_range;
    logic [WI_W-1:0]      rd_addr;
    logic                 mem_we;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORD_BITS-1:0] word_cur;
    logic                 found;
    logic [WB_LOG-1:0]    found_idx;

    assign o_stall     = (r_state != ST_IDLE);
    assign accept      = i_valid & (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_load    = (r_state == ST_HOLD) & (~r_out_vld | ~i_stall);

    assign limit_sat = (CMP_W'(r_fs_size) > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS)
                                                               : CMP_W'(r_fs_size);
    assign limit     = LIM_W'(limit_sat);
    assign lim_m1    = BLK_W'(limit - 1'b1);
    assign in_range  = RNG_W'(i_block_number) < RNG_W'(MAX_BLOCKS);

    // a word never written reads as all free
    assign word_cur = r_rd_vld ? r_rd_data : '0;

    bba_find #(
        .WORD_BITS (WORD_BITS)
    ) u_find (
        .i_word  (word_cur),
        .i_rem   (r_rem),
        .i_last  (r_chk == r_last),
        .o_found (found),
        .o_idx   (found_idx)
    );

    always_comb begin
        n_state       = r_state;
        n_chk         = r_chk;
        n_last        = r_last;
        n_rem         = r_rem;
        n_do_wr       = r_do_wr;
        n_pend_blk    = r_pend_blk;
        n_pend_status = r_pend_status;
        rd_addr       = r_chk;
        mem_we        = 1'b0;
        wr_data       = word_cur;
        case (r_state)
            ST_IDLE: begin
                if (i_operation == OP_FREE) begin
                    rd_addr = WI_W'(i_block_number >> WB_LOG);
                end else begin
                    rd_addr = '0;
                end
                if (accept) begin
                    if (i_operation == OP_FREE) begin
                        n_chk         = rd_addr;
                        n_rem         = i_block_number[WB_LOG-1:0];
                        n_do_wr       = (i_block_number != '0) & in_range;
                        n_pend_blk    = '0;
                        n_pend_status = STATUS_OK;
                        n_state       = ST_FREE;
                    end else if (limit == '0) begin
                        n_pend_blk    = '0;
                        n_pend_status = STATUS_FULL;
                        n_state       = ST_HOLD;
                    end else begin
                        n_chk   = '0;
                        n_last  = WI_W'(lim_m1 >> WB_LOG);
                        n_rem   = lim_m1[WB_LOG-1:0];
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_FREE: begin
                // clear the block's bit; block 0 and blocks past the map stay as they are
                mem_we  = r_do_wr;
                wr_data = word_cur & ~(WORD_BITS'(1) << r_rem);
                n_state = ST_HOLD;
            end
            ST_SCAN: begin
                // fetch the following word while this one is checked
                rd_addr = r_chk + 1'b1;
                if (found) begin
                    mem_we        = 1'b1;
                    wr_data       = word_cur | (WORD_BITS'(1) << found_idx);
                    n_pend_blk    = BLK_IO_W'(BLK_W'({r_chk, found_idx}));
                    n_pend_status = STATUS_OK;
                    n_state       = ST_HOLD;
                end else if (r_chk == r_last) begin
                    n_pend_blk    = '0;
                    n_pend_status = STATUS_FULL;
                    n_state       = ST_HOLD;
                end else begin
                    n_chk = r_chk + 1'b1;
                end
            end
            ST_HOLD: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // bitmap memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_chk] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_vld  <= r_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_vld     <= '0;
            r_out_vld <= 1'b0;
            r_fs_size <= FS_SIZE_RST;
        end else begin
            r_state <= n_state;
            if (mem_we) begin
                r_vld[r_chk] <= 1'b1;
            end
            if (i_cfg_valid) begin
                r_fs_size <= i_cfg_data;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk         <= n_chk;
        r_last        <= n_last;
        r_rem         <= n_rem;
        r_do_wr       <= n_do_wr;
        r_pend_blk    <= n_pend_blk;
        r_pend_status <= n_pend_status;
        if (out_load) begin
            r_out_blk    <= r_pend_blk;
            r_out_status <= r_pend_status;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_allocated_block = r_out_blk;
    assign o_status          = r_out_status;

endmodule

// File: test/bitmap_block_allocator_tb.sv
`timescale 1ns / 1ps

module bitmap_block_allocator_tb;
    import bba_pkg::*;

    localparam int NWORDS         = DEF_MAX_BLOCKS / DEF_WORD_BITS;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int STUCK_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 20;
    localparam int MAX_REPORTS    = 10;
    localparam int FILL_SIZE      = 320;

    typedef struct packed {
        logic [BLK_IO_W-1:0] block;
        logic                status;
    } t_grant;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} t_stall_mode;

    class t_alloc_scoreboard;
        bit [DEF_WORD_BITS-1:0] used_map [NWORDS];
        bit [CFG_W-1:0]         fs_size;
        t_grant                 grants [$];
        int mismatches;
        int n_alloc;
        int n_full;
        int n_free;
        int n_sizes;

        function new();
            foreach (used_map[w]) used_map[w] = '0;
            fs_size    = FS_SIZE_RST;
            mismatches = 0;
            n_alloc    = 0;
            n_full     = 0;
            n_free     = 0;
            n_sizes    = 0;
        endfunction

        function void set_size(input logic [CFG_W-1:0] v);
            fs_size = v;
            n_sizes++;
        endfunction

        function bit is_used(input int b);
            return used_map[b / DEF_WORD_BITS][b % DEF_WORD_BITS];
        endfunction

        function int pending();
            return grants.size();
        endfunction

        // first used block other than 0 at or after from, wrapping; 0 when there is none
        function int next_used(input int from);
            int k;
            int b;
            for (k = 0; k < DEF_MAX_BLOCKS; k++) begin
                b = (from + k) % DEF_MAX_BLOCKS;
                if (b != 0 && is_used(b)) return b;
            end
            return 0;
        endfunction

        function int free_count(input int lim);
            int b;
            int n;
            n = 0;
            for (b = 0; b < lim; b++) if (!is_used(b)) n++;
            return n;
        endfunction

        // work out the grant for one accepted request word
        function void note_request(input logic op, input logic [BLK_IO_W-1:0] blk);
            t_grant g;
            int     lim;
            int     b;
            g.block  = '0;
            g.status = STATUS_OK;
            if (op == OP_FREE) begin
                n_free++;
                // a free of block 0 is ignored
                if (blk != '0)
                    used_map[int'(blk) / DEF_WORD_BITS][int'(blk) % DEF_WORD_BITS] = 1'b0;
            end else begin
                n_alloc++;
                lim      = (fs_size > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : int'(fs_size);
                g.status = STATUS_FULL;
                for (b = 0; b < lim; b++) begin
                    // skip a word with no free bit
                    if (b % DEF_WORD_BITS == 0 && &used_map[b / DEF_WORD_BITS]) begin
                        b += DEF_WORD_BITS - 1;
                        continue;
                    end
                    if (!is_used(b)) begin
                        used_map[b / DEF_WORD_BITS][b % DEF_WORD_BITS] = 1'b1;
                        g.block  = BLK_IO_W'(b);
                        g.status = STATUS_OK;
                        break;
                    end
                end
                if (g.status == STATUS_FULL) n_full++;
            end
            grants.push_back(g);
        endfunction

        function void check_result(input logic [BLK_IO_W-1:0] blk, input logic st);
            t_grant want;
            if (grants.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result word block=%0d status=%0b",
                             $realtime, blk, st);
                return;
            end
            want = grants.pop_front();
            if (want.block !== blk || want.status !== st) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: mismatch block exp=%0d got=%0d status exp=%0b got=%0b",
                             $realtime, want.block, blk, want.status, st);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic                i_operation;
    logic [BLK_IO_W-1:0] i_block_number;
    logic                o_valid;
    logic                i_stall;
    logic [BLK_IO_W-1:0] o_allocated_block;
    logic                o_status;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_data;

    t_alloc_scoreboard sb;
    bit                offering;
    bit                steady;
    bit                holdoff_req;
    int                burst_left;
    int                stuck_cycles = 0;

    bitmap_block_allocator u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_operation       (i_operation),
        .i_block_number    (i_block_number),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_allocated_block (o_allocated_block),
        .o_status          (o_status),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver: changing stall pattern, plus a long hold-off on request
    initial begin
        t_stall_mode mode;
        int          mode_left;
        int          holdoff_left;
        i_stall      = 1'b0;
        mode         = STALL_NONE;
        mode_left    = 0;
        holdoff_left = 0;
        forever begin
            @(posedge i_clk);
            if (holdoff_req) begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_req  = 1'b0;
            end
            if (mode_left == 0) begin
                case ($urandom_range(0, 2))
                    0: mode = STALL_NONE;
                    1: mode = STALL_LIGHT;
                    default: mode = STALL_HEAVY;
                endcase
                mode_left = $urandom_range(32, 256);
            end else begin
                mode_left--;
            end
            if (holdoff_left != 0) begin
                holdoff_left--;
                i_stall <= 1'b1;
            end else begin
                case (mode)
                    STALL_NONE:  i_stall <= 1'b0;
                    STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    default:     i_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_size(i_cfg_data);
            if (i_valid && !o_stall) sb.note_request(i_operation, i_block_number);
            if (o_valid && !i_stall) sb.check_result(o_allocated_block, o_status);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results outstanding",
                     STUCK_LIMIT, sb.pending());
            $display("simulation failed");
            $finish;
        end
    end

    // offer one request word and hold it until taken; bursts end in a random gap unless steady
    task automatic send_item(input logic op, input logic [BLK_IO_W-1:0] blk);
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_block_number <= blk;
        offering = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            if (!steady) begin
                i_valid <= 1'b0;
                offering = 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    endtask

    // stop offering and wait until every grant has come back
    task automatic settle();
        if (offering) begin
            i_valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly allocations and frees of used blocks, some frees of arbitrary blocks
    task automatic run_mix(input int n);
        int i;
        int r;
        int u;
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                send_item(OP_ALLOC, BLK_IO_W'($urandom));
            end else if (r < 85) begin
                u = sb.next_used($urandom_range(1, DEF_MAX_BLOCKS - 1));
                send_item(OP_FREE, BLK_IO_W'(u));
            end else begin
                send_item(OP_FREE, BLK_IO_W'($urandom_range(0, DEF_MAX_BLOCKS - 1)));
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] sizes [10];
        int               p;
        int               n;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_operation    = OP_ALLOC;
        i_block_number = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = FS_SIZE_RST;
        offering       = 1'b0;
        steady         = 1'b0;
        holdoff_req    = 1'b0;
        burst_left     = 0;
        sb             = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset size: first fit, ignored free of block 0, frees of unused and top blocks
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '1);
        send_item(OP_ALLOC, '0);
        send_item(OP_FREE, '0);
        send_item(OP_ALLOC, '0);
        send_item(OP_FREE, BLK_IO_W'(1));
        send_item(OP_ALLOC, '0);
        send_item(OP_FREE, '1);
        send_item(OP_FREE, BLK_IO_W'(2));
        send_item(OP_FREE, BLK_IO_W'(2));
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '1);
        // small, zero and oversize areas; free above the area end
        write_size(CFG_W'(2));
        send_item(OP_ALLOC, '0);
        write_size('0);
        send_item(OP_ALLOC, '0);
        write_size(CFG_W'(1));
        send_item(OP_ALLOC, '0);
        send_item(OP_FREE, BLK_IO_W'(3));
        write_size('1);
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '0);

        sizes = '{CFG_W'(5), CFG_W'(64), CFG_W'(65), CFG_W'(130), CFG_W'(1),
                  '1, CFG_W'(4097), FS_SIZE_RST, '0, '0};
        sizes[8] = CFG_W'($urandom_range(1, DEF_MAX_BLOCKS));
        sizes[9] = CFG_W'($urandom_range(1, DEF_MAX_BLOCKS));
        for (p = 0; p < 10; p++) begin
            write_size(sizes[p]);
            steady = ($urandom_range(0, 3) == 0);
            if (p == 3) begin
                // keep offering while the result side is held off
                holdoff_req = 1'b1;
                steady      = 1'b1;
            end
            run_mix(40);
            if (p == 6) settle();
            run_mix(40);
        end

        // fill a bounded area, then run into it
        write_size(CFG_W'(FILL_SIZE));
        n      = sb.free_count(FILL_SIZE);
        steady = 1'b1;
        repeat (n + 3) send_item(OP_ALLOC, BLK_IO_W'($urandom));
        steady = 1'b0;
        send_item(OP_ALLOC, '0);
        send_item(OP_FREE, BLK_IO_W'(FILL_SIZE - 1));
        send_item(OP_FREE, BLK_IO_W'(200));
        send_item(OP_FREE, BLK_IO_W'(3000));
        send_item(OP_ALLOC, '0);
        write_size(CFG_W'(100));
        send_item(OP_ALLOC, '0);
        send_item(OP_FREE, BLK_IO_W'(3500));
        write_size(FS_SIZE_RST);
        repeat (4) send_item(OP_ALLOC, '0);
        run_mix(100);

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d allocations (%0d refused) and %0d frees",
                 sb.n_alloc, sb.n_full, sb.n_free);
        $display("over %0d area sizes including zero, one, full and oversize; %0d mismatches",
                 sb.n_sizes, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
